// File: rtl/core/accel_tilt_roll_pitch_top_macros.svh
// ------------------------------------------------------------------------
// accel tilt assertion macros
// shared concurrent assertion forms for the tilt pipeline
// ------------------------------------------------------------------------
`ifndef ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH

// same-cycle implication
`define ATRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATRP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/atrp_pkg.sv
// ------------------------------------------------------------------------
// atrp package
// widths, angle constants and arctangent table of the tilt pipeline
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package atrp_pkg;

    localparam int RAW_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int ACC_W    = 28;
    localparam int SQ_W     = 56;
    localparam int ROOT_W   = 29;
    localparam int ANG_IN_W = 29;
    localparam int NORM_W   = 41;
    localparam int CRD_W    = 44;
    localparam int ACC_A_W  = 25;
    localparam int ROLL_W   = 17;
    localparam int PITCH_W  = 16;
    localparam int ITER     = 23;
    localparam int SQRT_IT  = 28;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic signed [ROLL_W-1:0] DEG180_Q8 = 17'sd46080;
    localparam logic signed [ROLL_W-1:0] DEG90_Q8  = 17'sd23040;
    localparam logic signed [ACC_A_W-1:0] DEG90_Q16 = 25'sd5898240;

    localparam logic [22:0] ATAN_TAB [0:ITER-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379,
        23'd117304, 23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667,
        23'd1833, 23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1
    };

    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctrl_t;

    typedef struct packed {
        logic zero_y;
        logic zero_x;
        logic xx_neg;
        logic yy_neg;
    } ang_flags_t;

endpackage

// File: rtl/core/atrp_in_if.sv
// ------------------------------------------------------------------------
// atrp sample channel
// valid/ready channel carrying one raw accelerometer sample per beat
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atrp_in_if
    import atrp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] x_raw;
    logic signed [RAW_W-1:0] y_raw;
    logic signed [RAW_W-1:0] z_raw;
    logic                    read_ok;

    modport source (output valid, x_raw, y_raw, z_raw, read_ok, input ready);
    modport sink   (input valid, x_raw, y_raw, z_raw, read_ok, output ready);
endinterface

// File: rtl/core/atrp_out_if.sv
// ------------------------------------------------------------------------
// atrp result channel
// valid/ready channel carrying scaled axes and tilt angles per beat
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atrp_out_if
    import atrp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [ACC_W-1:0]   x_accel;
    logic signed [ACC_W-1:0]   y_accel;
    logic signed [ACC_W-1:0]   z_accel;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;

    modport source (output valid, x_accel, y_accel, z_accel, roll_angle, pitch_angle,
                    input ready);
    modport sink   (input valid, x_accel, y_accel, z_accel, roll_angle, pitch_angle,
                    output ready);
endinterface

// File: rtl/core/accel_tilt_roll_pitch_top.sv
// ------------------------------------------------------------------------
// accel tilt roll pitch top
// scales one accelerometer sample and derives roll and pitch angles
// ------------------------------------------------------------------------
// Accepts one sample per cycle unless the sink stalls, and returns one result per sample,
// in order. A sample passes 61 register stages, the last being the output register. The
// depth is set by the square-root pipeline (one root bit per stage) feeding the pitch
// atan2, whose 23 cordic stages run one rotation each. A stalled sink holds the whole
// pipeline. The scale register is written through cfg_we/cfg_wdata.
`timescale 1ns / 1ps
`include "accel_tilt_roll_pitch_top_macros.svh"

module accel_tilt_roll_pitch_top
    import atrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    atrp_in_if.sink            sample,
    atrp_out_if.source         result
);

    localparam int SIDE_W = 3 * ACC_W + 1;

    logic [SCALE_W-1:0] scale_reg;
    logic               en;
    logic               out_vld_reg;

    assign en           = !out_vld_reg || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // scale stage
    logic signed [ACC_W-1:0] xa_reg, ya_reg, za_reg;
    logic                    ok1_reg, v1_reg;

    function automatic logic signed [ACC_W-1:0] scale_axis(
        input logic signed [RAW_W-1:0] raw,
        input logic [SCALE_W-1:0]      sc
    );
        logic signed [RAW_W-1:0]   q;
        logic signed [ACC_W:0]     p;
        q = raw / 16;
        p = $signed(q[RAW_W-5:0]) * $signed({1'b0, sc});
        return p[ACC_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg  <= scale_axis(sample.x_raw, scale_reg);
            ya_reg  <= scale_axis(sample.y_raw, scale_reg);
            za_reg  <= scale_axis(sample.z_raw, scale_reg);
            ok1_reg <= sample.read_ok;
        end
    end

    // squares stage
    logic [SQ_W-1:0]        y2_reg, z2_reg;
    logic [SIDE_W-1:0]      s2_reg;
    logic                   v2_reg;
    logic signed [SQ_W-1:0] y_sq, z_sq;

    always_comb
    begin
        y_sq = ya_reg * ya_reg;
        z_sq = za_reg * za_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg <= y_sq;
            z2_reg <= z_sq;
            s2_reg <= {xa_reg, ya_reg, za_reg, ok1_reg};
        end
    end

    // hypotenuse
    pipe_ctrl_t        sq_ctrl;
    logic              sq_vld;
    logic [ROOT_W-1:0] h;
    logic [SIDE_W-1:0] s3;

    assign sq_ctrl.adv = en;
    assign sq_ctrl.vld = v2_reg;

    atrp_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sq_ctrl),
        .n_in     (y2_reg + z2_reg),
        .side_in  (s2_reg),
        .vld_out  (sq_vld),
        .root_out (h),
        .side_out (s3)
    );

    // angles
    logic signed [ACC_W-1:0]    x3, y3, z3;
    logic                       ok3;
    pipe_ctrl_t                 ang_ctrl;
    logic signed [ANG_IN_W-1:0] roll_yy, roll_xx, pitch_yy, pitch_xx;

    assign {x3, y3, z3, ok3} = s3;
    assign ang_ctrl.adv      = en;
    assign ang_ctrl.vld      = sq_vld;
    assign roll_yy           = -ANG_IN_W'(y3);
    assign roll_xx           = ANG_IN_W'(z3);
    assign pitch_yy          = ANG_IN_W'(x3);
    assign pitch_xx          = $signed(h);

    logic                     roll_vld, pitch_vld, ok4;
    logic signed [ROLL_W-1:0] roll, pitch;
    logic [SIDE_W-1:0]        s4;

    atrp_angle #(.SIDE_W(SIDE_W)) u_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ang_ctrl),
        .yy       (roll_yy),
        .xx       (roll_xx),
        .side_in  (s3),
        .vld_out  (roll_vld),
        .angle    (roll),
        .side_out (s4)
    );

    atrp_angle #(.SIDE_W(1)) u_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ang_ctrl),
        .yy       (pitch_yy),
        .xx       (pitch_xx),
        .side_in  (ok3),
        .vld_out  (pitch_vld),
        .angle    (pitch),
        .side_out (ok4)
    );

    // output register
    logic signed [ACC_W-1:0]   xo_reg, yo_reg, zo_reg;
    logic signed [ROLL_W-1:0]  ro_reg;
    logic signed [PITCH_W-1:0] po_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= roll_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ok4)
            begin
                xo_reg <= s4[SIDE_W-1 -: ACC_W];
                yo_reg <= s4[2*ACC_W : ACC_W+1];
                zo_reg <= s4[ACC_W:1];
                ro_reg <= roll;
                po_reg <= pitch[PITCH_W-1:0];
            end
            else
            begin
                xo_reg <= '0;
                yo_reg <= '0;
                zo_reg <= '0;
                ro_reg <= '0;
                po_reg <= '0;
            end
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.x_accel     = xo_reg;
    assign result.y_accel     = yo_reg;
    assign result.z_accel     = zo_reg;
    assign result.roll_angle  = ro_reg;
    assign result.pitch_angle = po_reg;

    `ATRP_ASSERT_IMP(a_ang_align, clk, rst_n, roll_vld || pitch_vld,
                     roll_vld == pitch_vld, "roll and pitch pipelines out of step")
    `ATRP_ASSERT_NXT(a_out_hold, clk, rst_n, out_vld_reg && !result.ready,
                     out_vld_reg, "result beat dropped while stalled")
    `ATRP_ASSERT_NXT(a_out_load, clk, rst_n, roll_vld && en,
                     out_vld_reg, "finished beat not loaded into output")

endmodule

// File: rtl/core/atrp_isqrt.sv
// ------------------------------------------------------------------------
// atrp pipelined square root
// one result bit per stage, rounded to nearest at the end
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module atrp_isqrt
    import atrp_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctrl_t        ctrl,
    input  logic [SQ_W-1:0]   n_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RW = SQ_W + 1;

    logic [SQ_W-1:0]   n_reg    [0:SQRT_IT];
    logic [RW-1:0]     r_reg    [0:SQRT_IT];
    logic [SIDE_W-1:0] side_reg [0:SQRT_IT];
    logic              v_reg    [0:SQRT_IT];
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] sidef_reg;
    logic              vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            v_reg[0] <= ctrl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            n_reg[0]    <= n_in;
            r_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < SQRT_IT; i++)
    begin : g_it
        localparam logic [RW-1:0] BIT = RW'(1) << (SQ_W - 2 - 2 * i);
        logic [RW-1:0]   t;
        logic [SQ_W-1:0] n_next;
        logic [RW-1:0]   r_next;

        always_comb
        begin
            t = r_reg[i] + BIT;
            if ({1'b0, n_reg[i]} >= t)
            begin
                n_next = n_reg[i] - t[SQ_W-1:0];
                r_next = (r_reg[i] >> 1) + BIT;
            end
            else
            begin
                n_next = n_reg[i];
                r_next = r_reg[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (ctrl.adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                n_reg[i+1]    <= n_next;
                r_reg[i+1]    <= r_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        root_next = r_reg[SQRT_IT][ROOT_W-1:0];
        if ({1'b0, n_reg[SQRT_IT]} > r_reg[SQRT_IT])
        begin
            root_next = root_next + ROOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            vf_reg <= v_reg[SQRT_IT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            root_reg  <= root_next;
            sidef_reg <= side_reg[SQRT_IT];
        end
    end

    assign vld_out  = vf_reg;
    assign root_out = root_reg;
    assign side_out = sidef_reg;

endmodule

// File: rtl/core/atrp_angle.sv
// ------------------------------------------------------------------------
// atrp pipelined atan2
// prep, three normalize stages, cordic vectoring stages and quadrant fixup
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module atrp_angle
    import atrp_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pipe_ctrl_t                 ctrl,
    input  logic signed [ANG_IN_W-1:0] yy,
    input  logic signed [ANG_IN_W-1:0] xx,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       vld_out,
    output logic signed [ROLL_W-1:0]   angle,
    output logic [SIDE_W-1:0]          side_out
);

    // prep stage
    logic [NORM_W-1:0] ax_reg, ay_reg;
    ang_flags_t        pf_reg;
    logic [SIDE_W-1:0] ps_reg;
    logic              pv_reg;

    logic [ANG_IN_W-1:0] ax_abs, ay_abs;

    always_comb
    begin
        ax_abs = xx[ANG_IN_W-1] ? ANG_IN_W'(-xx) : ANG_IN_W'(xx);
        ay_abs = yy[ANG_IN_W-1] ? ANG_IN_W'(-yy) : ANG_IN_W'(yy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            pv_reg <= ctrl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            ax_reg        <= NORM_W'(ax_abs);
            ay_reg        <= NORM_W'(ay_abs);
            pf_reg.zero_y <= (yy == '0);
            pf_reg.zero_x <= (xx == '0);
            pf_reg.xx_neg <= xx[ANG_IN_W-1];
            pf_reg.yy_neg <= yy[ANG_IN_W-1];
            ps_reg        <= side_in;
        end
    end

    // normalize so the larger operand has its top bit set
    logic [NORM_W-1:0] nx_reg [0:3];
    logic [NORM_W-1:0] ny_reg [0:3];
    ang_flags_t        nf_reg [0:3];
    logic [SIDE_W-1:0] ns_reg [0:3];
    logic              nv_reg [0:3];

    always_comb
    begin
        nx_reg[0] = ax_reg;
        ny_reg[0] = ay_reg;
        nf_reg[0] = pf_reg;
        ns_reg[0] = ps_reg;
        nv_reg[0] = pv_reg;
    end

    for (genvar n = 0; n < 3; n++)
    begin : g_norm
        localparam int K1 = 32 >> (2 * n);
        localparam int K2 = K1 / 2;
        logic [NORM_W-1:0] tx, ty;

        always_comb
        begin
            tx = nx_reg[n];
            ty = ny_reg[n];
            if (((tx | ty) >> (NORM_W - K1)) == '0)
            begin
                tx = tx << K1;
                ty = ty << K1;
            end
            if (((tx | ty) >> (NORM_W - K2)) == '0)
            begin
                tx = tx << K2;
                ty = ty << K2;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nv_reg[n+1] <= 1'b0;
            end
            else if (ctrl.adv)
            begin
                nv_reg[n+1] <= nv_reg[n];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                nx_reg[n+1] <= tx;
                ny_reg[n+1] <= ty;
                nf_reg[n+1] <= nf_reg[n];
                ns_reg[n+1] <= ns_reg[n];
            end
        end
    end

    // cordic vectoring
    logic signed [CRD_W-1:0]   cx_reg [0:ITER];
    logic signed [CRD_W-1:0]   cy_reg [0:ITER];
    logic signed [ACC_A_W-1:0] ca_reg [0:ITER];
    ang_flags_t                cf_reg [0:ITER];
    logic [SIDE_W-1:0]         cs_reg [0:ITER];
    logic                      cv_reg [0:ITER];

    always_comb
    begin
        cx_reg[0] = $signed({{(CRD_W-NORM_W){1'b0}}, nx_reg[3]});
        cy_reg[0] = $signed({{(CRD_W-NORM_W){1'b0}}, ny_reg[3]});
        ca_reg[0] = '0;
        cf_reg[0] = nf_reg[3];
        cs_reg[0] = ns_reg[3];
        cv_reg[0] = nv_reg[3];
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_crd
        localparam logic signed [ACC_A_W-1:0] TAB = $signed(ACC_A_W'(ATAN_TAB[i]));
        logic signed [CRD_W-1:0]   x_next, y_next;
        logic signed [ACC_A_W-1:0] a_next;

        always_comb
        begin
            if (!cy_reg[i][CRD_W-1])
            begin
                x_next = cx_reg[i] + (cy_reg[i] >>> i);
                y_next = cy_reg[i] - (cx_reg[i] >>> i);
                a_next = ca_reg[i] + TAB;
            end
            else
            begin
                x_next = cx_reg[i] - (cy_reg[i] >>> i);
                y_next = cy_reg[i] + (cx_reg[i] >>> i);
                a_next = ca_reg[i] - TAB;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (ctrl.adv)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                cx_reg[i+1] <= x_next;
                cy_reg[i+1] <= y_next;
                ca_reg[i+1] <= a_next;
                cf_reg[i+1] <= cf_reg[i];
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    // clamp, round and restore quadrant
    logic signed [ACC_A_W-1:0] a_cl;
    logic [ACC_A_W-1:0]        a_rnd;
    logic signed [ROLL_W-1:0]  q0, ang_next;
    ang_flags_t                ff;

    always_comb
    begin
        ff   = cf_reg[ITER];
        a_cl = ca_reg[ITER];
        if (a_cl < 0)
        begin
            a_cl = '0;
        end
        else if (a_cl > DEG90_Q16)
        begin
            a_cl = DEG90_Q16;
        end
        a_rnd = ACC_A_W'(a_cl) + ACC_A_W'(128);
        q0    = $signed({1'b0, a_rnd[ROLL_W+6:8]});
        if (ff.zero_x)
        begin
            q0 = DEG90_Q8;
        end
        if (ff.xx_neg)
        begin
            q0 = DEG180_Q8 - q0;
        end
        ang_next = ff.yy_neg ? -q0 : q0;
        if (ff.zero_y)
        begin
            ang_next = ff.xx_neg ? -DEG180_Q8 : '0;
        end
    end

    logic signed [ROLL_W-1:0] ang_reg;
    logic [SIDE_W-1:0]        sf_reg;
    logic                     vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            vf_reg <= cv_reg[ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            ang_reg <= ang_next;
            sf_reg  <= cs_reg[ITER];
        end
    end

    assign vld_out  = vf_reg;
    assign angle    = ang_reg;
    assign side_out = sf_reg;

endmodule
